### hdl/sbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbr_pkg;
    localparam int MaxWidthDef  = 128;
    localparam int MaxHeightDef = 128;
    localparam int MaxAreaDef   = 16;

    localparam logic [7:0] PixWhite = 8'd255;
    localparam logic [7:0] PixBlack = 8'd0;

    localparam logic [1:0] RegFrameWidth  = 2'd0;
    localparam logic [1:0] RegFrameHeight = 2'd1;
    localparam logic [1:0] RegMinArea     = 2'd2;

    localparam logic KindWrite = 1'b0;
    localparam logic KindRead  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] col;
        logic [6:0] row;
        logic [7:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       kept;
        logic [4:0] count_seen;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_START,
        ST_START_RD,
        ST_STEP,
        ST_PROBE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH_RD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic do_write;
        logic start_init;
        logic step;
        logic probe_rd;
        logic scan_init;
        logic scan_next;
        logic accept_nb;
        logic mem_rd_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic in_frame;
        logic cap_hit;
        logic stack_empty;
        logic dir_done;
        logic nb_valid;
        logic nb_black;
        logic scan_done;
        logic scan_match;
    } t_status;

    // dx, dy per direction: up, up-left, left, down-left, down, down-right, right, up-right
    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        case (d)
            3'd1, 3'd2, 3'd3: step_dx = -2'sd1;
            3'd5, 3'd6, 3'd7: step_dx = 2'sd1;
            default: step_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        case (d)
            3'd0, 3'd1, 3'd7: step_dy = -2'sd1;
            3'd3, 3'd4, 3'd5: step_dy = 2'sd1;
            default: step_dy = 2'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

### hdl/small_blob_removal_core.sv
// channel | direction | handshake                       | word
// in      | input     | i_in_valid / o_in_ready         | t_in_word
// out     | output    | o_out_valid / i_out_ready       | t_out_word
// cfg     | input     | i_cfg_valid / o_cfg_ready       | index, data
// a write loads the word, then writes it to the frame memory; an in-frame read walks the search
// step by step, with a memory read per in-frame probe and, for a black probe, a scan of the
// visited entries up to the count; one memory port per probe sets the pace
// reset is synchronous, active low; the frame memory is not cleared
// a result waits in the output register until taken; no new word is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module small_blob_removal_core #(
    parameter int MAX_WIDTH  = sbr_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = sbr_pkg::MaxHeightDef,
    parameter int MAX_AREA   = sbr_pkg::MaxAreaDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sbr_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sbr_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import sbr_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sbr_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_AREA  (MAX_AREA)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

`ifndef SYNTHESIS
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while result pending");
    a_kept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kept) |-> (o_out_word.count_seen != 5'd0))
        else $error("kept with zero count");
    a_white_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.kept) |-> (o_out_word.pixel_out == PixWhite))
        else $error("dropped pixel not white");
`endif
endmodule
`default_nettype wire

### hdl/sbr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sbr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire sbr_pkg::t_status i_status,
    output sbr_pkg::t_cmd        o_cmd
);
    import sbr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!i_status.is_read) begin
                    o_cmd.do_write = 1'b1;
                    n_state = ST_IDLE;
                end else if (!i_status.in_frame) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.start_init = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.cap_hit || i_status.stack_empty) begin
                    o_cmd.mem_rd_start = 1'b1;
                    n_state = ST_START_RD;
                end else begin
                    o_cmd.step = 1'b1;
                    if (!i_status.dir_done && i_status.nb_valid) begin
                        o_cmd.probe_rd = 1'b1;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.nb_black) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_match) begin
                    n_state = ST_STEP;
                end else if (i_status.scan_done) begin
                    o_cmd.accept_nb = 1'b1;
                    n_state = ST_STEP;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_START_RD: begin
                n_state = ST_FINISH_RD;
            end
            ST_FINISH_RD: begin
                o_cmd.finish = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/sbr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sbr_datapath #(
    parameter int MAX_WIDTH  = sbr_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = sbr_pkg::MaxHeightDef,
    parameter int MAX_AREA   = sbr_pkg::MaxAreaDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sbr_pkg::t_in_word i_in_word,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    input  wire sbr_pkg::t_cmd     i_cmd,
    output sbr_pkg::t_status       o_status,
    output sbr_pkg::t_out_word     o_out_word
);
    import sbr_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int SW = $clog2(MAX_AREA);
    localparam int CW = $clog2(MAX_AREA + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [7:0] r_fw, r_fh;
    logic [4:0] r_ma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 8'd128;
            r_fh <= 8'd128;
            r_ma <= 5'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegFrameWidth:  r_fw <= i_cfg_data;
                RegFrameHeight: r_fh <= i_cfg_data;
                RegMinArea:     r_ma <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective sizes (wide enough to hold the maxima)
    logic [10:0] w_eff, h_eff;
    logic [CW-1:0] cap;
    always_comb begin
        w_eff = ({3'd0, r_fw} > 11'(MAX_WIDTH))  ? 11'(MAX_WIDTH)  : {3'd0, r_fw};
        h_eff = ({3'd0, r_fh} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {3'd0, r_fh};
        if (r_ma == 5'd0) begin
            cap = CW'(1);
        end else if (7'(r_ma) > 7'(MAX_AREA)) begin
            cap = CW'(MAX_AREA);
        end else begin
            cap = CW'(r_ma);
        end
    end

    t_in_word r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
    end

    logic [XW-1:0] item_x;
    logic [YW-1:0] item_y;
    assign item_x = XW'(r_item.col);
    assign item_y = YW'(r_item.row);
    logic in_frame;
    assign in_frame = (11'(r_item.col) < w_eff) && (11'(r_item.row) < h_eff);

    // frame memory
    logic [7:0] r_mem [DEPTH];
    logic [AW-1:0] mem_raddr;
    logic [7:0] r_mem_q;
    logic mem_re;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && in_frame) begin
            r_mem[{item_y, item_x}] <= r_item.pixel_in;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // search state
    logic [AW-1:0] r_stk_pos [MAX_AREA];
    logic [3:0]    r_stk_dir [MAX_AREA];
    logic [AW-1:0] r_vis     [MAX_AREA];
    logic [CW-1:0] r_sp, r_cnt, r_scan;
    logic [AW-1:0] r_nb;

    logic [SW-1:0] top;
    assign top = SW'(r_sp - CW'(1));
    logic [AW-1:0] tpos;
    logic [3:0]    tdir;
    assign tpos = r_stk_pos[top];
    assign tdir = r_stk_dir[top];

    logic [XW+1:0] nx;
    logic [YW+1:0] ny;
    logic nb_valid;
    always_comb begin
        nx = $signed({2'b00, tpos[XW-1:0]}) + (XW+2)'(step_dx(tdir[2:0]));
        ny = $signed({2'b00, tpos[AW-1:XW]}) + (YW+2)'(step_dy(tdir[2:0]));
        nb_valid = !nx[XW+1] && !ny[YW+1]
                   && (11'(nx) < w_eff) && (11'(ny) < h_eff);
    end

    assign mem_re = i_cmd.probe_rd || i_cmd.mem_rd_start;
    assign mem_raddr = i_cmd.probe_rd ? {ny[YW-1:0], nx[XW-1:0]} : {item_y, item_x};

    logic [SW-1:0] scan_idx;
    assign scan_idx = SW'(r_scan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_cnt  <= '0;
            r_scan <= '0;
        end else begin
            if (i_cmd.start_init) begin
                r_vis[0] <= {item_y, item_x};
                r_cnt <= CW'(1);
                r_stk_pos[0] <= {item_y, item_x};
                r_stk_dir[0] <= 4'd0;
                r_sp <= CW'(1);
            end
            if (i_cmd.step) begin
                if (tdir[3]) begin
                    r_sp <= r_sp - CW'(1);
                end else begin
                    r_stk_dir[top] <= tdir + 4'd1;
                end
            end
            if (i_cmd.probe_rd) begin
                r_nb <= {ny[YW-1:0], nx[XW-1:0]};
            end
            if (i_cmd.scan_init) begin
                r_scan <= '0;
            end
            if (i_cmd.scan_next) begin
                r_scan <= r_scan + CW'(1);
            end
            if (i_cmd.accept_nb) begin
                r_vis[SW'(r_cnt)] <= r_nb;
                r_cnt <= r_cnt + CW'(1);
                if ((r_cnt + CW'(1)) < cap && r_sp < CW'(MAX_AREA)) begin
                    r_stk_pos[SW'(r_sp)] <= r_nb;
                    r_stk_dir[SW'(r_sp)] <= 4'd0;
                    r_sp <= r_sp + CW'(1);
                end
            end
        end
    end

    always_comb begin
        o_status.is_read     = (r_item.kind == KindRead);
        o_status.in_frame    = in_frame;
        o_status.cap_hit     = (r_cnt >= cap);
        o_status.stack_empty = (r_sp == '0);
        o_status.dir_done    = tdir[3];
        o_status.nb_valid    = nb_valid;
        o_status.nb_black    = (r_mem_q == PixBlack);
        o_status.scan_done   = (r_scan >= r_cnt);
        o_status.scan_match  = (r_scan < r_cnt) && (r_vis[scan_idx] == r_nb);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (!in_frame) begin
                o_out_word.pixel_out  <= PixWhite;
                o_out_word.kept       <= 1'b0;
                o_out_word.count_seen <= 5'd0;
            end else begin
                o_out_word.kept       <= (r_cnt >= cap);
                o_out_word.pixel_out  <= (r_cnt >= cap) ? r_mem_q : PixWhite;
                o_out_word.count_seen <= 5'(r_cnt);
            end
        end
    end
endmodule
`default_nettype wire
